[rtl/sfbc_pkg.sv]
// package for the sha-256 feistel block cipher
// holds the sha-256 round constants, iv, helper functions and the control struct
package sfbc_pkg;

  localparam int RCNT_W = 7;
  localparam logic [RCNT_W-1:0] DEFAULT_ROUNDS = 7'd16;

  localparam logic [1:0] CFG_KEY_HIGH    = 2'd0;
  localparam logic [1:0] CFG_KEY_LOW     = 2'd1;
  localparam logic [1:0] CFG_ROUND_COUNT = 2'd2;

  localparam logic [255:0] SHA_IV = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  // round constant lookup
  function automatic logic [31:0] sha_k(input logic [5:0] idx);
    logic [31:0] k;
    case (idx)
      6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // controller to datapath commands
  typedef struct packed {
    logic       load;      // capture input halves
    logic       start;     // build message block, load iv
    logic       step;      // one compression step
    logic       finish;    // apply digest to halves
    logic       last;      // final round: no swap
    logic [5:0] step_idx;
    logic [RCNT_W-1:0] round_num;
  } sfbc_cmd_t;

endpackage

[rtl/sfbc_if.sv]
// valid/ready stream interface carrying one beat of payload
// no dependencies
interface sfbc_if #(parameter int W = 8) (input logic clk);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/sfbc_datapath.sv]
// datapath: halves, message schedule window and sha-256 working state
// depends on sfbc_pkg
module sfbc_datapath
  import sfbc_pkg::*;
#(
  parameter int HALF_BITS = 64,
  parameter int KEY_BITS  = 128
) (
  input  logic                 clk,
  input  sfbc_cmd_t            cmd,
  input  logic [HALF_BITS-1:0] left_in,
  input  logic [HALF_BITS-1:0] right_in,
  input  logic [KEY_BITS-1:0]  key,
  output logic [HALF_BITS-1:0] left_res,
  output logic [HALF_BITS-1:0] right_res
);
  localparam int MSG_BITS = HALF_BITS + 16 + KEY_BITS;
  localparam int PAD_BITS = 512 - MSG_BITS - 64;
  localparam logic [63:0] BIT_LEN = 64'(MSG_BITS);

  logic [HALF_BITS-1:0] left_r, right_r;
  logic [511:0] w_r, w_nxt;
  logic [255:0] s_r, s_nxt;
  logic [511:0] blk;
  logic [31:0] a, b, c, d, e, f, g, h, t1, t2, w0, s0, s1, wn;
  logic [63:0] top;
  logic [HALF_BITS-1:0] hv;

  // padded single message block
  assign blk = {right_r, 8'h00, 8'(cmd.round_num), key, 1'b1,
                {(PAD_BITS-1){1'b0}}, BIT_LEN};

  // one compression step, schedule window shifts by one word
  always_comb begin
    {a, b, c, d, e, f, g, h} = s_r;
    w0 = w_r[511:480];
    t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
         + sha_k(cmd.step_idx) + w0;
    t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
    s0 = rotr(w_r[479:448], 7) ^ rotr(w_r[479:448], 18) ^ (w_r[479:448] >> 3);
    s1 = rotr(w_r[63:32], 17) ^ rotr(w_r[63:32], 19) ^ (w_r[63:32] >> 10);
    wn = w0 + s0 + w_r[223:192] + s1;
    s_nxt = {t1 + t2, a, b, c, d + t1, e, f, g};
    w_nxt = {w_r[479:0], wn};
    top = {SHA_IV[255:224] + s_r[255:224], SHA_IV[223:192] + s_r[223:192]};
    hv = top[63 -: HALF_BITS];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      left_r  <= left_in;
      right_r <= right_in;
    end else if (cmd.finish) begin
      if (cmd.last) begin
        left_r <= left_r ^ hv;
      end else begin
        left_r  <= right_r;
        right_r <= left_r ^ hv;
      end
    end
    if (cmd.start) begin
      w_r <= blk;
      s_r <= SHA_IV;
    end else if (cmd.step) begin
      w_r <= w_nxt;
      s_r <= s_nxt;
    end
  end

  assign left_res  = left_r;
  assign right_res = right_r;
endmodule

[rtl/sfbc_ctrl.sv]
// controller: sequences rounds and compression steps, owns the handshakes
// depends on sfbc_pkg
module sfbc_ctrl
  import sfbc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              encrypt,
  input  logic [RCNT_W-1:0] round_count,
  output logic              out_valid,
  input  logic              out_ready,
  output sfbc_cmd_t         cmd
);
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_INIT = 3'd1;
  localparam logic [2:0] ST_RUN  = 3'd2;
  localparam logic [2:0] ST_FIN  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic [RCNT_W-1:0] rnd_r, rnd_nxt, n_r, n_nxt;
  logic [5:0] step_r, step_nxt;
  logic enc_r, enc_nxt;
  logic in_fire;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_DONE);
  assign in_fire   = in_valid && in_ready;

  // round number as hashed: ascending or descending
  always_comb begin
    cmd = '0;
    cmd.load = in_fire;
    cmd.step_idx = step_r;
    cmd.round_num = enc_r ? rnd_r : RCNT_W'(n_r - rnd_r - 1'b1);
    cmd.last = (rnd_r == RCNT_W'(n_r - 1'b1));
    cmd.start = (state_r == ST_INIT);
    cmd.step = (state_r == ST_RUN);
    cmd.finish = (state_r == ST_FIN);
  end

  // each round: init, 64 compression steps, then a state that applies the digest
  always_comb begin
    state_nxt = state_r;
    rnd_nxt = rnd_r;
    n_nxt = n_r;
    step_nxt = step_r;
    enc_nxt = enc_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          enc_nxt = encrypt;
          n_nxt = round_count;
          rnd_nxt = '0;
          state_nxt = (round_count == '0) ? ST_DONE : ST_INIT;
        end
      end
      ST_INIT: begin
        step_nxt = '0;
        state_nxt = ST_RUN;
      end
      ST_RUN: begin
        step_nxt = step_r + 6'd1;
        if (step_r == 6'd63) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        rnd_nxt = rnd_r + 1'b1;
        state_nxt = cmd.last ? ST_DONE : ST_INIT;
      end
      ST_DONE: begin
        if (out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      rnd_r <= '0;
      n_r <= '0;
      step_r <= '0;
      enc_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rnd_r <= rnd_nxt;
      n_r <= n_nxt;
      step_r <= step_nxt;
      enc_r <= enc_nxt;
    end
  end
endmodule

[rtl/sha256_feistel_block_cipher.sv]
// Feistel block cipher with a sha-256 round function, one block at a time.
// An accepted beat runs round_count rounds before its result (a pass-through beat
// with zero rounds goes straight to the result); each round is an init state, 64
// steps of the single shared compression unit and a state that applies the digest.
// A new beat is taken once the previous result beat has been delivered. The user
// must make configuration writes only while the block is idle; the block itself
// does not enforce it. Key bytes are taken from the top of key_high:key_low.
module sha256_feistel_block_cipher
  import sfbc_pkg::*;
#(
  parameter int HALF_BITS = 64,
  parameter int KEY_BITS  = 128
) (
  input  logic  clk,
  input  logic  rst_n,
  sfbc_if.sink  in_ch,
  sfbc_if.source out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  logic [63:0] key_high_r, key_low_r;
  logic [RCNT_W-1:0] round_count_r;
  logic [127:0] key_cat;
  logic [KEY_BITS-1:0] key;
  logic [HALF_BITS-1:0] left_res, right_res;
  sfbc_cmd_t cmd;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0;
      key_low_r <= '0;
      round_count_r <= DEFAULT_ROUNDS;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KEY_HIGH:    key_high_r <= cfg_data;
        CFG_KEY_LOW:     key_low_r <= cfg_data;
        CFG_ROUND_COUNT: round_count_r <= cfg_data[RCNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign key_cat = {key_high_r, key_low_r};
  assign key = key_cat[127 -: KEY_BITS];

  sfbc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .encrypt(in_ch.data[128]), .round_count(round_count_r),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .cmd(cmd)
  );

  sfbc_datapath #(.HALF_BITS(HALF_BITS), .KEY_BITS(KEY_BITS)) u_dp (
    .clk(clk), .cmd(cmd),
    .left_in(in_ch.data[64 +: HALF_BITS]), .right_in(in_ch.data[0 +: HALF_BITS]),
    .key(key), .left_res(left_res), .right_res(right_res)
  );

  // payload: {left, right}
  assign out_ch.data = {64'(left_res), 64'(right_res)};

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid)) else $error("ready while result pending");
  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
    else $error("result changed while stalled");
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready) else $error("ready after accept");
`endif
endmodule
